// ===== sv/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg: shared constants and types of the LRU key/value cache
// Sizes of the entry store and the control and status bundles that pass
// between the sequencer and the entry table.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 5;

    // Register index of capacity_in_use on the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    // Commands from the sequencer to the entry table.
    typedef struct packed {
        logic             touch;   // make entry idx the most recent
        logic             insert;  // insert a new entry, evicting if full
        logic [IDX_W-1:0] idx;
    } t_tbl_cmd;

    // Status from the entry table to the sequencer.
    typedef struct packed {
        logic [CAPACITY-1:0] valid;
        logic                evict;  // an insert now would evict
        logic [IDX_W-1:0]    slot;   // entry an insert now would fill
    } t_tbl_stat;

endpackage

// ===== sv/lkv_ram.sv =====
// ----------------------------------------------------------------------------
// lkv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lkv_entry_table.sv =====
// ----------------------------------------------------------------------------
// lkv_entry_table: valid bits, recency ranks and fill count
// Keeps one rank per entry (0 is most recent) and applies touch and insert
// commands, choosing the victim and the free slot for an insert.
// ----------------------------------------------------------------------------
module lkv_entry_table
    import lkv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_capacity,
    input  t_tbl_cmd         i_cmd,
    output t_tbl_stat        o_stat
);

    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]    r_rank [CAPACITY];
    logic [IDX_W-1:0]    n_rank [CAPACITY];
    logic [CNT_W-1:0]    r_count, n_count;

    logic [CNT_W-1:0]    eff_cap;
    logic                evict;
    logic [IDX_W-1:0]    last_rank;
    logic [IDX_W-1:0]    touch_rank;
    logic [CAPACITY-1:0] victim;
    logic [CAPACITY-1:0] free;
    logic [IDX_W-1:0]    slot;

    // A capacity of zero acts as one, anything above the store acts as full size.
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (CNT_W'(i_capacity) > CNT_W'(CAPACITY)) begin
            eff_cap = CNT_W'(CAPACITY);
        end else begin
            eff_cap = CNT_W'(i_capacity);
        end
    end

    assign evict      = (r_count >= eff_cap);
    assign last_rank  = IDX_W'(r_count - CNT_W'(1));
    assign touch_rank = r_rank[i_cmd.idx];

    // Ranks of valid entries are distinct, so the least recent entry is the
    // one holding rank count-1.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            victim[i] = r_valid[i] && (r_rank[i] == last_rank);
            free[i]   = !r_valid[i] || (evict && victim[i]);
        end
    end

    always_comb begin
        slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (free[i]) begin
                slot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;
        if (i_cmd.touch) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_valid[i] && (r_rank[i] < touch_rank)) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
            n_rank[i_cmd.idx] = '0;
        end else if (i_cmd.insert) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (evict && victim[i]) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
            n_valid[slot] = 1'b1;
            n_rank[slot]  = '0;
            n_count = evict ? r_count : r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_rank  <= n_rank;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.evict = evict;
    assign o_stat.slot  = slot;

endmodule

// ===== sv/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key/value cache with LRU
// Flow: a request is taken only in the idle state; the single key RAM read port
// and the one shared key comparator walk all 16 entries, then an update state
// follows and the result beat waits until the output register can take it.
// Reset (synchronous, active low) empties the cache and sets capacity to 16.
// Key and value RAMs are not cleared; valid bits guard every key compare.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
    import lkv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic        s_axis_tuser,   // [0] req_type (0 get, 1 put)
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] hit, [32:1] read_value, [33] evicted
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_RESP   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_put, n_put;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_val, n_val;
    logic [CNT_W-1:0] r_idx, n_idx;          // next entry address to issue
    logic             r_chk, n_chk;          // key read data is in flight
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;  // entry that key read data belongs to
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_found_idx, n_found_idx;
    logic             r_hit, n_hit;
    logic             r_get_hit, n_get_hit;
    logic             r_ev, n_ev;
    logic             r_m_valid, n_m_valid;
    logic [39:0]      r_m_data, n_m_data;
    logic [CFG_W-1:0] r_cap, n_cap;

    logic             in_take;
    logic             out_load;
    logic             match;
    logic [KEY_W-1:0] key_rdata;
    logic [VAL_W-1:0] val_rdata;
    logic             val_we;
    logic [IDX_W-1:0] val_waddr;
    logic             val_re;
    logic [VAL_W-1:0] rd_value;
    t_tbl_cmd         tbl_cmd;
    t_tbl_stat        tbl_stat;

    // ------------------------------------------------------------------
    // Configuration port. Writes land at the access phase; the low two
    // address bits are the byte offset within the register word.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb begin
        n_cap = r_cap;
        if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            n_cap = pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CFG_W){1'b0}}, r_cap} : '0;

    // ------------------------------------------------------------------
    // Storage. Keys are read one entry per cycle during the scan; the
    // value RAM is read once for a get hit and written for any put.
    // ------------------------------------------------------------------
    lkv_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_cmd.insert),
        .i_waddr (tbl_stat.slot),
        .i_wdata (r_key),
        .i_re    ((r_state == ST_SCAN) && !r_idx[IDX_W]),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (key_rdata)
    );

    assign val_we    = (r_state == ST_UPDATE) && r_put;
    assign val_waddr = r_found ? r_found_idx : tbl_stat.slot;
    assign val_re    = (r_state == ST_UPDATE) && r_found && !r_put;

    lkv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_val),
        .i_re    (val_re),
        .i_raddr (r_found_idx),
        .o_rdata (val_rdata)
    );

    // Valid bits and recency ranks live in the entry table. It acts only
    // in the update cycle, after the scan has settled hit or miss.
    assign tbl_cmd.touch  = (r_state == ST_UPDATE) && r_found;
    assign tbl_cmd.insert = (r_state == ST_UPDATE) && !r_found && r_put;
    assign tbl_cmd.idx    = r_found_idx;

    lkv_entry_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_cap),
        .i_cmd      (tbl_cmd),
        .o_stat     (tbl_stat)
    );

    // ------------------------------------------------------------------
    // Sequencer. The shared comparator checks one stored key per cycle
    // against the request key; the first valid match wins.
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign match         = r_chk && tbl_stat.valid[r_chk_idx] && (key_rdata == r_key);

    // The result register may still hold an older beat; it is reloaded
    // only once the downstream side has taken that beat or in the same edge.
    assign out_load = (r_state == ST_RESP) && (!r_m_valid || m_axis_tready);
    assign rd_value = r_get_hit ? val_rdata : '0;

    always_comb begin
        n_state     = r_state;
        n_put       = r_put;
        n_key       = r_key;
        n_val       = r_val;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_hit       = r_hit;
        n_get_hit   = r_get_hit;
        n_ev        = r_ev;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_put   = s_axis_tuser;
                    n_key   = s_axis_tdata[KEY_W-1:0];
                    n_val   = s_axis_tdata[32 +: VAL_W];
                    n_idx   = '0;
                    n_chk   = 1'b0;
                    n_found = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!r_idx[IDX_W]) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                n_chk     = !r_idx[IDX_W];
                n_chk_idx = r_idx[IDX_W-1:0];
                if (match && !r_found) begin
                    n_found     = 1'b1;
                    n_found_idx = r_chk_idx;
                end
                if (r_chk && (r_chk_idx == IDX_W'(CAPACITY - 1))) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_hit     = r_found;
                n_get_hit = r_found && !r_put;
                n_ev      = !r_found && r_put && tbl_stat.evict;
                n_state   = ST_RESP;
            end
            ST_RESP: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: one result beat per request.
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (out_load) begin
            n_m_valid = 1'b1;
            n_m_data  = {6'd0, r_ev, rd_value, r_hit};
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chk     <= 1'b0;
            r_found   <= 1'b0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
            r_cap     <= CFG_W'(CAPACITY);
        end else begin
            r_state   <= n_state;
            r_chk     <= n_chk;
            r_found   <= n_found;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
            r_cap     <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_put       <= n_put;
        r_key       <= n_key;
        r_val       <= n_val;
        r_chk_idx   <= n_chk_idx;
        r_found_idx <= n_found_idx;
        r_hit       <= n_hit;
        r_get_hit   <= n_get_hit;
        r_ev        <= n_ev;
        r_m_data    <= n_m_data;
    end

endmodule

// ===== dv/lru_cache_checker.sv =====
// ----------------------------------------------------------------------------
// lru_cache_checker: response predictor and comparator for the LRU cache
// Watches the request, response and configuration channels, keeps its own
// copy of the entry table and recency ranks, and compares every response
// beat field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module lru_cache_checker
    import lkv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic        s_axis_tuser,   // [0] req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [0] hit, [32:1] read_value, [33] evicted
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } t_cache_response;

    t_cache_response  predicted_responses[$];

    logic [KEY_W-1:0] tbl_key[CAPACITY];
    logic [VAL_W-1:0] tbl_val[CAPACITY];
    bit               tbl_valid[CAPACITY];
    int               tbl_rank[CAPACITY];
    int               tbl_count;
    logic [CFG_W-1:0] cap_setting;
    int               fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic clear_table();
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_rank[i]  = 0;
        end
        tbl_count   = 0;
        cap_setting = CFG_W'(CAPACITY);
    endtask

    // Applies one request to the table copy and returns the response it causes.
    task automatic lookup_and_update(input logic is_put, input logic [KEY_W-1:0] key,
                                     input logic [VAL_W-1:0] val,
                                     output t_cache_response rsp);
        int found;
        int victim;
        int slot;
        int limit;
        int r;
        found = -1;
        victim = -1;
        slot = -1;
        rsp = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (found < 0 && tbl_valid[i] && tbl_key[i] == key)
                found = i;
        if (found >= 0) begin
            rsp.hit = 1'b1;
            if (is_put)
                tbl_val[found] = val;
            else
                rsp.read_value = tbl_val[found];
            r = tbl_rank[found];
            for (int i = 0; i < CAPACITY; i++)
                if (tbl_valid[i] && tbl_rank[i] < r)
                    tbl_rank[i]++;
            tbl_rank[found] = 0;
        end else if (is_put) begin
            limit = int'(cap_setting);
            if (limit < 1)
                limit = 1;
            if (limit > CAPACITY)
                limit = CAPACITY;
            if (tbl_count >= limit) begin
                for (int i = 0; i < CAPACITY; i++)
                    if (tbl_valid[i] && (victim < 0 || tbl_rank[i] > tbl_rank[victim]))
                        victim = i;
                if (victim >= 0) begin
                    tbl_valid[victim] = 1'b0;
                    tbl_rank[victim]  = 0;
                    if (tbl_count > 0)
                        tbl_count--;
                    rsp.evicted = 1'b1;
                end
            end
            for (int i = 0; i < CAPACITY; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
            if (slot >= 0) begin
                for (int i = 0; i < CAPACITY; i++)
                    if (tbl_valid[i])
                        tbl_rank[i]++;
                tbl_key[slot]   = key;
                tbl_val[slot]   = val;
                tbl_valid[slot] = 1'b1;
                tbl_rank[slot]  = 0;
                tbl_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_cache_response want;
        t_cache_response got;
        if (!i_rst_n) begin
            clear_table();
            predicted_responses.delete();
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
                cap_setting = pwdata[CFG_W-1:0];
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit        = m_axis_tdata[0];
                got.read_value = m_axis_tdata[32:1];
                got.evicted    = m_axis_tdata[33];
                if (predicted_responses.size() == 0) begin
                    $error("response beat with no request outstanding: %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = predicted_responses.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               want.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                lookup_and_update(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32], want);
                predicted_responses.push_back(want);
            end
            o_pending <= predicted_responses.size();
        end
    end

endmodule

// ===== dv/tb_lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit: testbench for the LRU key/value cache
// Drives get and put requests over the request stream and the capacity
// register over the configuration port, with random gaps on both streams.
// A directed opening is followed by random phases at several capacities;
// a separate checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit
    import lkv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       REQ_GET        = 1'b0;
    localparam logic       REQ_PUT        = 1'b1;
    localparam logic [2:0] CAP_ADDR       = {REG_CAPACITY, 2'b00};
    localparam int         NUM_PHASES     = 10;
    localparam int         PHASE_ITEMS    = 135;
    localparam int         HOLD_OFF_BEAT  = 100;
    localparam int         HOLD_OFF_LEN   = 400;
    localparam int         END_TAIL       = 40;
    localparam int         WATCHDOG_LIMIT = 4000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    // Key pool for the random phases; a small pool makes hits and evictions common.
    logic [31:0] key_pool[24];
    int          pool_size;
    bit          sender_steady = 1'b0;

    always #4 i_clk = ~i_clk;

    lru_key_value_cache_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lru_cache_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Mostly back-to-back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    // Offers one request beat and returns in the time step of its acceptance.
    // The valid is only lowered when a gap precedes the beat, so a valid that
    // stays high across back-to-back beats never sees two updates in one step.
    task automatic send_request(input logic kind, input logic [31:0] key,
                                input logic [31:0] val);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, key};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Waits until the checker holds no outstanding prediction. The pending
    // count is registered, so the task lets the clock advance before it is looked at.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes the capacity register once the cache has gone idle. Every request
    // produces a response, so an empty prediction queue means an idle block.
    task automatic write_capacity(input logic [31:0] val);
        s_tvalid <= 1'b0;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random phase: a capacity setting, a fresh key pool, then a run of
    // requests drawn mostly from the pool with a sprinkling of stray keys.
    task automatic run_random_phase(input int phase);
        int          cap;
        logic [31:0] key;
        cap = (phase < 8) ? int'(phase == 0 ? 16 : phase == 1 ? 1 : phase == 2 ? 0 :
                                 phase == 3 ? 31 : phase == 4 ? 17 : phase == 5 ? 2 :
                                 phase == 6 ? 5 : 8)
                          : $urandom_range(0, 31);
        // Upper register bits carry junk; only the low five bits are taken.
        write_capacity({27'($urandom), 5'(cap)});
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 24; i++)
            key_pool[i] = $urandom;
        pool_size     = $urandom_range(1, 24);
        sender_steady = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 88)
                key = key_pool[$urandom_range(0, pool_size - 1)];
            else
                key = $urandom;
            send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, key, $urandom);
        end
        sender_steady = 1'b0;
    endtask

    // Response side: random stalls after each beat, stretches with no stall,
    // and one long hold-off that backs the cache up into its request side.
    initial begin
        int  stall;
        int  beats;
        bit  steady;
        stall = 0;
        beats = 0;
        steady = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (m_tvalid && m_tready) begin
                    beats++;
                    steady = ((beats / 150) % 3 == 2);
                    if (beats == HOLD_OFF_BEAT)
                        stall = HOLD_OFF_LEN;
                    else if (!steady)
                        stall = pick_gap();
                end
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    stall--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // The run ends as a failure if no beat moves on any port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset capacity of sixteen. A get on the
        // empty cache misses, then the extreme keys and values go in.
        send_request(REQ_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(REQ_PUT, 32'h0000_0000, 32'h8000_0000);
        send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // A put to a present key updates in place and reports a hit.
        send_request(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        for (int i = 1; i <= 4; i++)
            send_request(REQ_PUT, 32'(i), 32'(i * 32'h0101_0101));
        send_request(REQ_GET, 32'h1234_5678, 32'h0000_0000);

        // Capacity lowered below the six entries held: each insert evicts
        // exactly one entry, so the count holds steady.
        write_capacity(32'd2);
        send_request(REQ_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(REQ_PUT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        // A capacity of zero behaves like one.
        write_capacity(32'd0);
        send_request(REQ_PUT, 32'h0000_0010, 32'h0000_0001);
        send_request(REQ_PUT, 32'h0000_0020, 32'h0000_0002);
        send_request(REQ_GET, 32'h0000_0020, 32'h0000_0000);

        // A capacity above the table size behaves like the table size.
        write_capacity(32'd31);
        send_request(REQ_PUT, 32'h1111_1111, 32'hDEAD_BEEF);
        send_request(REQ_PUT, 32'h2222_2222, 32'h0BAD_F00D);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);

        for (int p = 0; p < NUM_PHASES; p++)
            run_random_phase(p);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (END_TAIL) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lkv_pkg.sv
sv/lkv_ram.sv
sv/lkv_entry_table.sv
sv/lru_key_value_cache_unit.sv
dv/lru_cache_checker.sv
dv/tb_lru_key_value_cache_unit.sv
